/* hdl/dhle_pkg.sv */
// Shared types, constants and codes of the DNS host name label encoder.
package dhle_pkg;

	// Longest label that DNS allows, and the label index width it implies
	localparam int MAX_LABEL = 63;
	localparam int LEN_W     = $clog2(MAX_LABEL + 1);
	// Label store: two banks, one filling while the other drains
	localparam int BANK_DEPTH = 2 ** LEN_W;
	localparam int RAM_DEPTH  = 2 * BANK_DEPTH;
	localparam int ADDR_W     = LEN_W + 1;
	// Byte and budget widths
	localparam int BYTE_W   = 8;
	localparam int BUDGET_W = 8;
	localparam logic [BUDGET_W-1:0] BUDGET_RESET = 8'd255;
	// Register index of the output budget
	localparam int REG_OUTPUT_BUDGET = 0;
	// Command queue between front and back
	localparam int QDEPTH = 2;
	localparam int QP_W   = $clog2(QDEPTH);
	// The separator character
	localparam logic [BYTE_W-1:0] DOT_CHAR = 8'h2e;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_TOO_LONG = 2'd1,
		ST_BUDGET   = 2'd2
	} status_t;

	// Work handed from front to back
	typedef enum logic [1:0] {
		CMD_FLUSH,
		CMD_ERROR,
		CMD_ROOT
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic [LEN_W-1:0] len;
		logic             final_lbl;
		logic             bank;
		status_t          status;
	} cmd_t;

	// Back tells front that a bank has been drained
	typedef struct packed {
		logic valid;
		logic bank;
	} bank_rel_t;

	// Back sequencer states
	typedef enum logic {
		BK_IDLE,
		BK_DATA
	} back_state_t;

endpackage

/* hdl/dns_hostname_label_encoder_core.sv */
// Top level of the DNS host name label encoder: config port, front, queue, back.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------------
//  item    | in        | item_valid/item_stall | ch, end_of_name
//  result  | out       | res_valid/res_stall   | data_byte, append_root, run_last, status
//  config  | in (APB)  | psel/penable/pready   | paddr, pwdata, prdata (output_budget)
//
// A character item is taken when item_stall is low; a label of n characters is
// emitted as n+1 results, one per cycle unless res_stall holds them, read from the
// two-bank label store. One bank fills while the other drains, so with results
// taken the sustained rate is about one item per cycle. The front stalls only when
// the command queue is full or the bank it would fill holds a label not yet emitted.
// Reset is asynchronous and clears all control state; no clearing pass is needed.
module dns_hostname_label_encoder_core
	import dhle_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [1:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	// items
	input  logic              item_valid,
	output logic              item_stall,
	input  logic [BYTE_W-1:0] ch,
	input  logic              end_of_name,
	// results
	output logic              res_valid,
	input  logic              res_stall,
	output logic [BYTE_W-1:0] data_byte,
	output logic              append_root,
	output logic              run_last,
	output logic [1:0]        status
);

	logic [BUDGET_W-1:0] budget_reg_q;
	logic                push, pop, q_empty, q_full;
	cmd_t                push_cmd, head_cmd;
	bank_rel_t           rel;
	logic                wr_en, rd_en;
	logic [ADDR_W-1:0]   wr_addr, rd_addr;
	logic [BYTE_W-1:0]   wr_data, rd_data;

	// Config register: output budget at offset zero
	assign pready = 1'b1;
	assign prdata = {(32 - BUDGET_W)'(0), budget_reg_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_reg_q <= BUDGET_RESET;
		end else if (psel && penable && pwrite && pready
				&& (paddr == 2'(REG_OUTPUT_BUDGET * 4))) begin
			budget_reg_q <= pwdata[BUDGET_W-1:0];
		end
	end

	dhle_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.ch            (ch),
		.end_of_name   (end_of_name),
		.output_budget (budget_reg_q),
		.q_full        (q_full),
		.rel           (rel),
		.push          (push),
		.push_cmd      (push_cmd),
		.wr_en         (wr_en),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data)
	);

	dhle_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.empty    (q_empty),
		.full     (q_full)
	);

	dhle_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (RAM_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	dhle_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.head_cmd    (head_cmd),
		.pop         (pop),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data),
		.rel         (rel),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.data_byte   (data_byte),
		.append_root (append_root),
		.run_last    (run_last),
		.status      (status)
	);

	// Queue is never written while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full) else $error("command queue overflow");

	// A queued flush always carries a nonempty label
	a_flush_len: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head_cmd.kind == CMD_FLUSH) |-> (head_cmd.len != '0))
		else $error("empty label flushed");

	// Root flag only on the last result of an item
	a_root_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && append_root) |-> run_last)
		else $error("root flag on non-final result");

	// Error results are single zero bytes without root
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && status != ST_OK) |-> (run_last && !append_root && data_byte == '0))
		else $error("malformed error result");

endmodule

/* hdl/dhle_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module dhle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read, holds when not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* hdl/dhle_fifo.sv */
// Short command queue between the classifying front and the emitting back.
module dhle_fifo
	import dhle_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t head_cmd,
	output logic empty,
	output logic full
);

	cmd_t            entry_q [QDEPTH];
	logic [QP_W-1:0] wptr_q;
	logic [QP_W-1:0] rptr_q;
	logic [QP_W:0]   count_q;

	assign empty    = (count_q == '0);
	assign full     = (count_q == (QP_W+1)'(QDEPTH));
	assign head_cmd = entry_q[rptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* hdl/dhle_front.sv */
// Front: accepts characters, tracks label and budget, stores bytes, queues work.
module dhle_front
	import dhle_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  logic [BYTE_W-1:0]   ch,
	input  logic                end_of_name,
	input  logic [BUDGET_W-1:0] output_budget,
	input  logic                q_full,
	input  bank_rel_t           rel,
	output logic                push,
	output cmd_t                push_cmd,
	output logic                wr_en,
	output logic [ADDR_W-1:0]   wr_addr,
	output logic [BYTE_W-1:0]   wr_data
);

	logic [LEN_W-1:0]    len_q, len_d, len_e;
	logic [BUDGET_W-1:0] budget_q, budget_d, budget_e;
	logic                failed_q, failed_d, failed_e;
	logic                in_name_q, in_name_d;
	logic                wbank_q, wbank_d;
	logic [1:0]          busy_q, busy_d;
	logic                accept;
	logic [BUDGET_W:0]   cost;
	logic [BUDGET_W:0]   diff;

	// Hold off while the queue is full or the fill bank is still draining
	assign item_stall = q_full || busy_q[wbank_q];
	assign accept     = item_valid && !item_stall;

	// Label cost and saturating budget after a flush
	assign cost = (BUDGET_W+1)'(len_e) + (BUDGET_W+1)'(1);
	assign diff = {1'b0, budget_e} - cost;

	assign wr_addr = {wbank_q, len_e};
	assign wr_data = ch;

	// Classification of the accepted item
	always_comb begin
		// Name start view of the state
		len_e    = in_name_q ? len_q : '0;
		budget_e = in_name_q ? budget_q : output_budget;
		failed_e = in_name_q ? failed_q : 1'b0;

		len_d     = len_q;
		budget_d  = budget_q;
		failed_d  = failed_q;
		in_name_d = in_name_q;
		wbank_d   = wbank_q;
		push      = 1'b0;
		wr_en     = 1'b0;

		push_cmd.kind      = CMD_FLUSH;
		push_cmd.len       = len_e;
		push_cmd.final_lbl = end_of_name;
		push_cmd.bank      = wbank_q;
		push_cmd.status    = ST_OK;

		if (accept) begin
			len_d     = len_e;
			budget_d  = budget_e;
			failed_d  = failed_e;
			in_name_d = 1'b1;
			if (end_of_name) begin
				if (!failed_e) begin
					push = 1'b1;
					if (len_e != '0) begin
						wbank_d = ~wbank_q;
					end else begin
						push_cmd.kind = CMD_ROOT;
					end
				end
				len_d     = '0;
				failed_d  = 1'b0;
				in_name_d = 1'b0;
			end else if (failed_e) begin
				// dropped until end of name
			end else if (ch == DOT_CHAR) begin
				if (len_e != '0) begin
					push     = 1'b1;
					wbank_d  = ~wbank_q;
					len_d    = '0;
					budget_d = diff[BUDGET_W] ? '0 : diff[BUDGET_W-1:0];
				end
			end else if (len_e >= LEN_W'(MAX_LABEL)) begin
				push            = 1'b1;
				push_cmd.kind   = CMD_ERROR;
				push_cmd.status = ST_TOO_LONG;
				failed_d        = 1'b1;
			end else if (BUDGET_W'(len_e) >= budget_e) begin
				push            = 1'b1;
				push_cmd.kind   = CMD_ERROR;
				push_cmd.status = ST_BUDGET;
				failed_d        = 1'b1;
			end else begin
				wr_en = 1'b1;
				len_d = len_e + 1'b1;
			end
		end

		// Bank ownership: set on flush, released by back
		busy_d = busy_q;
		if (rel.valid) begin
			busy_d[rel.bank] = 1'b0;
		end
		if (push && push_cmd.kind == CMD_FLUSH) begin
			busy_d[wbank_q] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= '0;
			budget_q  <= BUDGET_RESET;
			failed_q  <= 1'b0;
			in_name_q <= 1'b0;
			wbank_q   <= 1'b0;
			busy_q    <= '0;
		end else begin
			len_q     <= len_d;
			budget_q  <= budget_d;
			failed_q  <= failed_d;
			in_name_q <= in_name_d;
			wbank_q   <= wbank_d;
			busy_q    <= busy_d;
		end
	end

endmodule

/* hdl/dhle_back.sv */
// Back: takes queued work and emits length, label bytes, errors and roots.
module dhle_back
	import dhle_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  cmd_t              head_cmd,
	output logic              pop,
	output logic              rd_en,
	output logic [ADDR_W-1:0] rd_addr,
	input  logic [BYTE_W-1:0] rd_data,
	output bank_rel_t         rel,
	output logic              res_valid,
	input  logic              res_stall,
	output logic [BYTE_W-1:0] data_byte,
	output logic              append_root,
	output logic              run_last,
	output logic [1:0]        status
);

	back_state_t       state_q, state_d;
	cmd_t              cur_q;
	logic [LEN_W-1:0]  idx_q, idx_d;
	logic              adv;
	logic              load;
	logic              at_end;
	logic              valid_q;
	logic [BYTE_W-1:0] data_d;
	logic              root_d, last_d;
	status_t           stat_d;

	// Output register advances when empty or taken
	assign adv       = !valid_q || !res_stall;
	assign at_end    = (idx_q == (cur_q.len - LEN_W'(1)));
	assign res_valid = valid_q;

	// Sequencer: next state and outputs
	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		pop       = 1'b0;
		load      = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = {cur_q.bank, idx_q};
		rel.valid = 1'b0;
		rel.bank  = cur_q.bank;
		data_d    = '0;
		root_d    = 1'b0;
		last_d    = 1'b1;
		stat_d    = ST_OK;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty && adv) begin
					pop  = 1'b1;
					load = 1'b1;
					unique case (head_cmd.kind)
						CMD_FLUSH: begin
							data_d  = BYTE_W'(head_cmd.len);
							last_d  = 1'b0;
							rd_en   = 1'b1;
							rd_addr = {head_cmd.bank, LEN_W'(0)};
							idx_d   = '0;
							state_d = BK_DATA;
						end
						CMD_ERROR: begin
							stat_d = head_cmd.status;
						end
						default: begin
							// root alone: data zero, ok
						end
					endcase
				end
			end
			BK_DATA: begin
				if (adv) begin
					load   = 1'b1;
					data_d = rd_data;
					last_d = at_end;
					root_d = at_end && cur_q.final_lbl;
					if (at_end) begin
						rel.valid = 1'b1;
						state_d   = BK_IDLE;
					end else begin
						rd_en   = 1'b1;
						rd_addr = {cur_q.bank, idx_q + 1'b1};
						idx_d   = idx_q + 1'b1;
					end
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (load) begin
				valid_q <= 1'b1;
			end else if (!res_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Current command and output payload
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head_cmd;
		end
		if (load) begin
			data_byte   <= data_d;
			append_root <= root_d;
			run_last    <= last_d;
			status      <= stat_d;
		end
	end

endmodule

/* dv/dns_hostname_label_encoder_core_test.sv */
// Self-checking testbench of the DNS host name label encoder core.
module dns_hostname_label_encoder_core_test;
	import dhle_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RAND_PHASES       = 6;
	localparam int PHASE_ITEMS       = 65;

	typedef struct {
		logic [BYTE_W-1:0] ch;
		logic              eon;
	} name_char_t;

	typedef struct {
		logic [BYTE_W-1:0] data;
		logic              root;
		logic              last;
		status_t           status;
	} wire_byte_t;

	// Clock, reset and block ports
	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [1:0]        paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              item_valid = 1'b0;
	logic              item_stall;
	logic [BYTE_W-1:0] ch = '0;
	logic              end_of_name = 1'b0;
	logic              res_valid;
	logic              res_stall = 1'b0;
	logic [BYTE_W-1:0] data_byte;
	logic              append_root;
	logic              run_last;
	logic [1:0]        status;

	// Idle rates in percent, set per phase
	int gap_pct = 0;
	int stall_pct = 0;

	// Pending items, expected wire bytes, bookkeeping
	name_char_t pend_q[$];
	wire_byte_t wire_q[$];
	int pushed_count = 0;
	int accepted_count = 0;
	int err_count = 0;
	int phase_items = 0;
	bit gen_dropping = 0;

	// Predictor state
	logic [BYTE_W-1:0] budget_reg = BUDGET_RESET;
	logic [BYTE_W-1:0] lbl_buf [64];
	int                lbl_len = 0;
	int                bytes_left = 0;
	bit                name_open = 0;
	bit                name_dropped = 0;

	name_char_t nxt;
	wire_byte_t want;

	dns_hostname_label_encoder_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.ch          (ch),
		.end_of_name (end_of_name),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.data_byte   (data_byte),
		.append_root (append_root),
		.run_last    (run_last),
		.status      (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// One line per mismatch, and count it
	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] exp_val);
		$display("ERROR at %0t: %s: got %0h, wanted %0h", $time, what, got, exp_val);
		err_count++;
	endtask

	// Emit length byte and label bytes of the buffered label
	task automatic flush_label(input bit is_final);
		logic [BYTE_W-1:0] b;
		bit                at_end;
		for (int i = 0; i <= lbl_len; i++) begin
			b = (i == 0) ? BYTE_W'(lbl_len) : lbl_buf[i-1];
			at_end = (i == lbl_len);
			wire_q.push_back('{b, at_end & is_final, at_end, ST_OK});
		end
		bytes_left = (lbl_len + 1 > bytes_left) ? 0 : bytes_left - (lbl_len + 1);
		lbl_len = 0;
	endtask

	// Predict the wire bytes that one accepted item causes
	task automatic encode_item(input logic [BYTE_W-1:0] c, input logic eon);
		if (!name_open) begin
			name_open = 1;
			bytes_left = budget_reg;
			lbl_len = 0;
			name_dropped = 0;
		end
		if (eon) begin
			if (!name_dropped) begin
				if (lbl_len > 0)
					flush_label(1);
				else
					wire_q.push_back('{'0, 1'b0, 1'b1, ST_OK});
			end
			lbl_len = 0;
			name_dropped = 0;
			name_open = 0;
		end else if (!name_dropped) begin
			if (c == DOT_CHAR) begin
				if (lbl_len > 0)
					flush_label(0);
			end else if (lbl_len + 1 > MAX_LABEL) begin
				name_dropped = 1;
				wire_q.push_back('{'0, 1'b0, 1'b1, ST_TOO_LONG});
			end else if (lbl_len + 1 > bytes_left) begin
				name_dropped = 1;
				wire_q.push_back('{'0, 1'b0, 1'b1, ST_BUDGET});
			end else begin
				lbl_buf[lbl_len] = c;
				lbl_len++;
			end
		end
	endtask

	// Driver: present pending items, random gaps; random result stalls
	always @(posedge clk) begin
		if (arst_n) begin
			res_stall <= ($urandom_range(99) < stall_pct);
			if (!item_valid || !item_stall) begin
				if (pend_q.size() > 0 && $urandom_range(99) >= gap_pct) begin
					nxt = pend_q.pop_front();
					item_valid <= 1'b1;
					ch <= nxt.ch;
					end_of_name <= nxt.eon;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: track register writes, predict accepted items, check results
	always @(posedge clk) begin
		if (arst_n) begin
			if (psel && penable && pwrite && pready && paddr == 2'(REG_OUTPUT_BUDGET * 4))
				budget_reg = pwdata[BYTE_W-1:0];
			if (item_valid && !item_stall) begin
				accepted_count++;
				encode_item(ch, end_of_name);
			end
			if (res_valid && !res_stall) begin
				if (wire_q.size() == 0) begin
					report_mismatch("result with none expected", data_byte, 8'h00);
				end else begin
					want = wire_q.pop_front();
					if (data_byte !== want.data)
						report_mismatch("data_byte", data_byte, want.data);
					if (append_root !== want.root)
						report_mismatch("append_root", 8'(append_root), 8'(want.root));
					if (run_last !== want.last)
						report_mismatch("run_last", 8'(run_last), 8'(want.last));
					if (status !== want.status)
						report_mismatch("status", 8'(status), 8'(want.status));
				end
			end
		end
	end

	task automatic push_item(input logic [BYTE_W-1:0] c, input logic eon);
		pend_q.push_back('{c, eon});
		pushed_count++;
		if (!gen_dropping)
			phase_items++;
		if (eon)
			gen_dropping = 0;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_item(s[i], 1'b0);
	endtask

	// Random character that is not a dot
	function automatic logic [BYTE_W-1:0] label_char();
		logic [BYTE_W-1:0] c;
		c = BYTE_W'($urandom_range(255));
		return (c == DOT_CHAR) ? (c ^ 8'h01) : c;
	endfunction

	// One random name: mostly well formed labels, some noise
	task automatic add_name();
		int nlab;
		int len;
		int r;
		r = $urandom_range(99);
		if (r < 10) begin
			len = $urandom_range(1, 20);
			for (int i = 0; i < len; i++)
				push_item(($urandom_range(99) < 30) ? DOT_CHAR : BYTE_W'($urandom_range(255)),
					1'b0);
		end else begin
			nlab = $urandom_range(1, 4);
			if ($urandom_range(99) < 10)
				push_item(DOT_CHAR, 1'b0);
			for (int l = 0; l < nlab; l++) begin
				r = $urandom_range(99);
				if (r < 5)
					len = $urandom_range(60, 66);
				else if (r < 8)
					len = 0;
				else
					len = $urandom_range(1, 12);
				for (int i = 0; i < len; i++) begin
					push_item(label_char(), 1'b0);
					// the rest of an overlong name is dropped by the block
					if (i == MAX_LABEL)
						gen_dropping = 1;
				end
				if (l < nlab - 1 || $urandom_range(99) < 10)
					push_item(DOT_CHAR, 1'b0);
			end
		end
		push_item(BYTE_W'($urandom_range(255)), 1'b1);
	endtask

	// Wait until every pending item is taken and every result has come
	task automatic drain();
		while (accepted_count != pushed_count || wire_q.size() != 0)
			@(posedge clk);
		repeat (32) @(posedge clk);
	endtask

	// APB write: setup cycle, then access until pready
	task automatic write_budget(input logic [BYTE_W-1:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 2'(REG_OUTPUT_BUDGET * 4);
		pwdata <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_idle(input int gap, input int stall);
		@(posedge clk);
		gap_pct <= gap;
		stall_pct <= stall;
	endtask

	initial begin
		int budgets [RAND_PHASES];
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		set_idle(38, 62);

		// Directed, reset budget: empty name, one char, empty labels, byte extremes
		push_item(8'h00, 1'b1);
		push_text("a");
		push_item(8'hff, 1'b1);
		push_text(".ab..c.");
		push_item(8'h00, 1'b1);
		push_item(8'h00, 1'b0);
		push_item(8'hff, 1'b0);
		push_item(DOT_CHAR, 1'b1);
		drain();

		// Budget of two: a label that just fits, then one that overflows
		write_budget(8'd2);
		push_text("ab");
		push_item(8'h41, 1'b1);
		push_text("abc.d");
		push_item(8'h00, 1'b1);
		drain();

		// Zero budget: first character fails, empty name still gives its root
		write_budget(8'd0);
		push_text("x.y");
		push_item(8'h00, 1'b1);
		push_item(8'h00, 1'b1);
		drain();

		// Random phases over several budgets and idle profiles
		budgets = '{255, 40, 12, 0, 64, 255};
		budgets[3] = $urandom_range(255);
		for (int p = 0; p < RAND_PHASES; p++) begin
			write_budget(BYTE_W'(budgets[p]));
			if (p < 2)
				set_idle(38, 62);
			else if (p < 4)
				set_idle(62, 38);
			else
				set_idle(0, 0);
			phase_items = 0;
			while (phase_items < PHASE_ITEMS)
				add_name();
			drain();
		end

		if (wire_q.size() != 0)
			report_mismatch("results never came", 8'(wire_q.size()), 8'h00);
		if (err_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
